### rtl/base64_bit_packer_unit_defines.svh
// Assertion macros used by the checker file of the Base64 bit packer.
// Depends on nothing; every macro samples on clk_i, and only B64BP_ASSERT is disabled while rst_ni is low.
`ifndef BASE64_BIT_PACKER_UNIT_DEFINES_SVH
`define BASE64_BIT_PACKER_UNIT_DEFINES_SVH

// Property checked outside reset.
`define B64BP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define B64BP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/b64bp_pkg.sv
// Package of the Base64 bit packer: widths, codes, queue entry types and
// the symbol-to-character function. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package b64bp_pkg;

  localparam int unsigned SymBits      = 6;
  localparam int unsigned DataBits     = 8;
  localparam int unsigned CountBits    = 4;
  localparam int unsigned CharBits     = 7;
  localparam int unsigned PendBits     = 3;
  localparam int unsigned MergeBits    = SymBits + DataBits;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QueuePtrBits = $clog2(QueueDepth);

  localparam logic [CharBits-1:0] CharUpperBase = 7'd65;  // 'A'
  localparam logic [CharBits-1:0] CharLowerBase = 7'd71;  // 'a' - 26
  localparam logic [CharBits-1:0] CharDigitOffs = 7'd4;   // 52 - '0'
  localparam logic [CharBits-1:0] CharPlus      = 7'd43;  // '+'
  localparam logic [CharBits-1:0] CharSlash     = 7'd47;  // '/'

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_FLUSH = 1'b1
  } req_type_e;

  typedef enum logic {
    BK_FIRST,
    BK_SECOND
  } back_state_e;

  typedef struct packed {
    logic               two;
    logic [SymBits-1:0] sym0;
    logic [SymBits-1:0] sym1;
  } sym_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [CharBits-1:0] sym_to_char(input logic [SymBits-1:0] sym);
    logic [CharBits-1:0] v;
    logic [CharBits-1:0] ch;
    v = {1'b0, sym};
    case (sym) inside
      [6'd0:6'd25]:  ch = CharUpperBase + v;
      [6'd26:6'd51]: ch = CharLowerBase + v;
      [6'd52:6'd61]: ch = v - CharDigitOffs;
      6'd62:         ch = CharPlus;
      default:       ch = CharSlash;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

### rtl/b64bp_fifo.sv
// Short queue of symbol entries between the front and back parts.
// Depends on b64bp_pkg for the entry type and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module b64bp_fifo import b64bp_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire sym_entry_t    entry_i,
  input  wire logic          pop_i,
  output sym_entry_t         head_o,
  output queue_status_t      status_o
);

  sym_entry_t                mem_q [QueueDepth];
  logic [QueuePtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueuePtrBits:0]     count_q, count_d;
  logic                      do_push, do_pop;

  always_comb begin
    status_o.full  = (count_q == (QueuePtrBits+1)'(QueueDepth));
    status_o.empty = (count_q == '0);
    do_push = push_i && !status_o.full;
    do_pop  = pop_i && !status_o.empty;
    head_o  = mem_q[rd_ptr_q];

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

### rtl/b64bp_front.sv
// Front part of the Base64 bit packer: accepts items, merges the new bits
// with the pending ones and queues the finished symbols. Depends on b64bp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64bp_front import b64bp_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 req_type_i,
  input  wire logic [DataBits-1:0]  data_bits_i,
  input  wire logic [CountBits-1:0] bit_count_i,
  input  wire queue_status_t        q_status_i,
  output logic                      push_o,
  output sym_entry_t                push_entry_o
);

  logic [SymBits-1:0]   acc_q, acc_d;
  logic [PendBits-1:0]  pend_q, pend_d;
  logic [CountBits-1:0] n_sat;
  logic [DataBits-1:0]  keep_mask;
  logic [MergeBits-1:0] merged;
  logic [CountBits-1:0] total;
  logic [CountBits-1:0] rem;
  logic [SymBits-1:0]   flush_sym;
  logic                 push_cand;
  logic                 accept;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && push_cand;

  always_comb begin
    // Counts above a byte saturate to a full byte.
    n_sat     = (bit_count_i > CountBits'(DataBits)) ? CountBits'(DataBits) : bit_count_i;
    keep_mask = ~({DataBits{1'b1}} << n_sat);
    merged    = ({{DataBits{1'b0}}, acc_q} << n_sat)
              | {{SymBits{1'b0}}, data_bits_i & keep_mask};
    total     = {1'b0, pend_q} + n_sat;
    flush_sym = acc_q << (PendBits'(SymBits) - pend_q);

    push_cand         = 1'b0;
    push_entry_o.two  = 1'b0;
    push_entry_o.sym0 = '0;
    push_entry_o.sym1 = '0;
    rem               = total;

    if (req_type_i == REQ_FLUSH) begin
      push_cand         = (pend_q != '0);
      push_entry_o.sym0 = flush_sym;
      acc_d             = '0;
      pend_d            = '0;
    end else begin
      if (total >= CountBits'(2 * SymBits)) begin
        push_cand         = 1'b1;
        push_entry_o.two  = 1'b1;
        push_entry_o.sym0 = SymBits'(merged >> (total - CountBits'(SymBits)));
        push_entry_o.sym1 = SymBits'(merged >> (total - CountBits'(2 * SymBits)));
        rem               = total - CountBits'(2 * SymBits);
      end else if (total >= CountBits'(SymBits)) begin
        push_cand         = 1'b1;
        push_entry_o.sym0 = SymBits'(merged >> (total - CountBits'(SymBits)));
        rem               = total - CountBits'(SymBits);
      end
      // Keep only the leftover bits so the upper accumulator bits stay zero.
      acc_d  = merged[SymBits-1:0] & ~({SymBits{1'b1}} << rem);
      pend_d = rem[PendBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pend_q <= '0;
    end else if (accept) begin
      acc_q  <= acc_d;
      pend_q <= pend_d;
    end
  end

endmodule

`default_nettype wire

### rtl/b64bp_back.sv
// Back part of the Base64 bit packer: drains queued symbols one character
// per cycle into the output register while the output is not stalled. Depends on b64bp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64bp_back import b64bp_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sym_entry_t     head_i,
  input  wire queue_status_t  q_status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [CharBits-1:0] out_char_o,
  output logic                last_o
);

  back_state_e        state_q, state_d;
  logic               out_valid_q;
  logic [CharBits-1:0] char_q;
  logic               last_q, last_d;
  logic [SymBits-1:0] sel_sym;
  logic               load;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = char_q;
  assign last_o      = last_q;

  always_comb begin
    load    = !q_status_i.empty && (!out_valid_q || out_ready_i);
    state_d = state_q;
    pop_o   = 1'b0;
    sel_sym = head_i.sym0;
    last_d  = !head_i.two;
    case (state_q)
      BK_FIRST: begin
        if (load) begin
          if (head_i.two) begin
            state_d = BK_SECOND;
          end else begin
            pop_o = 1'b1;
          end
        end
      end
      BK_SECOND: begin
        sel_sym = head_i.sym1;
        last_d  = 1'b1;
        if (load) begin
          pop_o   = 1'b1;
          state_d = BK_FIRST;
        end
      end
      default: begin
        state_d = BK_FIRST;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= sym_to_char(sel_sym);
      last_q <= last_d;
    end
  end

endmodule

`default_nettype wire

### rtl/base64_bit_packer_unit.sv
// Top level of the Base64 bit packer: front part, symbol queue, back part.
// Depends on b64bp_pkg, b64bp_front, b64bp_fifo and b64bp_back.
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+-------------------------------
//   in      | input     | in_valid_i / in_ready_o  | req_type_i, data_bits_i,
//           |           |                          | bit_count_i
//   out     | output    | out_valid_o / out_ready_i| out_char_o, last_o
//
// The front part takes one input transfer per cycle while the two-entry symbol
// queue has room; the back part moves one character per cycle into the output
// register while the output is not stalled, so an item that yields two characters
// holds the back until both of its characters have gone out.
// A character passes through the symbol queue and then the output register on its way out.
// Reset clears the pending bits, the queue and out_valid_o at once; out_char_o and last_o are not reset.
// A stall at the output fills the queue and then drops in_ready_o.
`timescale 1ns / 1ps
`default_nettype none

module base64_bit_packer_unit import b64bp_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 req_type_i,
  input  wire logic [DataBits-1:0]  data_bits_i,
  input  wire logic [CountBits-1:0] bit_count_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [CharBits-1:0]       out_char_o,
  output logic                      last_o
);

  // Queue status is shared by both sides: the front stalls on full, the
  // back idles on empty.
  queue_status_t q_status;
  sym_entry_t    push_entry;
  sym_entry_t    head_entry;
  logic          push;
  logic          pop;

  // Front: merges new bits with the pending ones and forms whole symbols.
  b64bp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .data_bits_i  (data_bits_i),
    .bit_count_i  (bit_count_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // Each queue entry carries the one or two symbols of a single item.
  b64bp_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .head_o   (head_entry),
    .status_o (q_status)
  );

  // Back: maps symbols to characters and marks the last one of each item.
  b64bp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_entry),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

### rtl/b64bp_checker.sv
// Port-level checks on the output channel of the Base64 bit packer, bound
// to the top level. Depends on base64_bit_packer_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "base64_bit_packer_unit_defines.svh"

module b64bp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [6:0] out_char_i,
  input wire logic       last_i
);

  `B64BP_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_ni |=> !out_valid_i, "output valid during reset")
  `B64BP_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i) && $stable(last_i), "stalled output changed")
  `B64BP_ASSERT(a_char_legal, out_valid_i |-> (out_char_i >= 7'd65 && out_char_i <= 7'd90) || (out_char_i >= 7'd97 && out_char_i <= 7'd122) || (out_char_i >= 7'd48 && out_char_i <= 7'd57) || out_char_i == 7'd43 || out_char_i == 7'd47, "character outside the alphabet")
  `B64BP_ASSERT(a_second_follows, out_valid_i && out_ready_i && !last_i |=> out_valid_i, "second character of an item did not follow")

endmodule

bind base64_bit_packer_unit b64bp_checker u_b64bp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_char_i  (out_char_o),
  .last_i      (last_o)
);

`default_nettype wire

### tb/base64_bit_packer_unit_tb.sv
// Self-checking testbench for base64_bit_packer_unit: random and directed bit groups
// and flushes, with a built-in predictor of the emitted Base64 characters.
// Depends on b64bp_pkg and the base64_bit_packer_unit RTL.
`timescale 1ns / 1ps

module base64_bit_packer_unit_tb;
  import b64bp_pkg::*;

  // The slowest correct run is far below this: every item waits at most the longest
  // idle gap that draw_idle gives, yields at most two characters, and each character
  // waits out at most one such stall at the output.
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned RandomItems = 1650;

  // One input transfer as the driver presents it.
  typedef struct {
    req_type_e             req;
    logic [DataBits-1:0]   data;
    logic [CountBits-1:0]  count;
  } packer_item_t;

  // One expected output character.
  typedef struct {
    logic [CharBits-1:0] ascii;
    logic                last;
  } char_entry_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic                 req_type_i  = 1'b0;
  logic [DataBits-1:0]  data_bits_i = '0;
  logic [CountBits-1:0] bit_count_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [CharBits-1:0]  out_char_o;
  logic                 last_o;

  base64_bit_packer_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .data_bits_i (data_bits_i),
    .bit_count_i (bit_count_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_o      (last_o)
  );

  // Free-running clock with a 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  packer_item_t pending_items[$];
  char_entry_t  expected_chars[$];

  // Predictor state: bits that have not yet formed a whole symbol, right-aligned,
  // and how many of them there are (0 to 5 between transfers).
  logic [SymBits-1:0]  held_bits  = '0;
  logic [PendBits-1:0] held_count = '0;

  string base64_alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  bit          no_idle_phase  = 1'b0;
  bit          timed_out      = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic [CharBits-1:0] symbol_ascii(input logic [SymBits-1:0] sym);
    byte c;
    c = base64_alphabet[sym];
    return c[CharBits-1:0];
  endfunction

  // Idle cycles before the next transfer on either side. During a no-idle phase
  // both sides run back to back so that the block sees its full rate.
  function automatic int unsigned draw_idle();
    return no_idle_phase ? 0 : $urandom_range(0, 5);
  endfunction

  // Works out the characters that one accepted transfer yields and queues them,
  // marking the final one of the transfer with last.
  task automatic predict_symbols(input req_type_e req, input logic [DataBits-1:0] data,
                                 input logic [CountBits-1:0] count);
    logic [SymBits-1:0] made[$];
    logic [SymBits-1:0] sym;
    char_entry_t        entry;
    int unsigned        n;
    if (req == REQ_FLUSH) begin
      // Pending bits are padded on the right with zeros; nothing pending, nothing out.
      if (held_count != 0) begin
        sym = held_bits << (SymBits - held_count);
        made.push_back(sym);
      end
      held_bits  = '0;
      held_count = '0;
    end else begin
      // Counts above eight saturate; a count of zero appends nothing.
      n = (count > DataBits) ? DataBits : count;
      for (int i = n; i > 0; i--) begin
        held_bits  = {held_bits[SymBits-2:0], data[i-1]};
        held_count = held_count + 1'b1;
        if (held_count == SymBits) begin
          made.push_back(held_bits);
          held_bits  = '0;
          held_count = '0;
        end
      end
    end
    for (int k = 0; k < made.size(); k++) begin
      entry.ascii = symbol_ascii(made[k]);
      entry.last  = (k == made.size() - 1);
      expected_chars.push_back(entry);
    end
  endtask

  task automatic add_write(input logic [DataBits-1:0] data, input logic [CountBits-1:0] count);
    packer_item_t item;
    item.req   = REQ_WRITE;
    item.data  = data;
    item.count = count;
    pending_items.push_back(item);
  endtask

  task automatic add_flush();
    packer_item_t item;
    item.req   = REQ_FLUSH;
    item.data  = DataBits'($urandom_range(0, 255));
    item.count = CountBits'($urandom_range(0, 15));
    pending_items.push_back(item);
  endtask

  // Cycle counter; it also switches the no-idle phase on and off now and then.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 200 == 0) begin
      no_idle_phase <= ($urandom_range(0, 3) == 0);
    end
  end

  // Input driver. A transfer completes at an edge where valid and ready are both
  // high; the predictor runs on the payload of that transfer. Once the slot is
  // free, the driver either idles for the drawn number of cycles, with random
  // junk on the payload, or presents the next pending item and holds it.
  always @(posedge clk_i or negedge rst_ni) begin : drive_input
    packer_item_t item;
    int unsigned  idle_left;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      req_type_i  <= REQ_WRITE;
      data_bits_i <= '0;
      bit_count_i <= '0;
      idle_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_symbols(req_type_e'(req_type_i), data_bits_i, bit_count_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (idle_left > 0 || pending_items.size() == 0) begin
          if (idle_left > 0) begin
            idle_left--;
          end
          in_valid_i  <= 1'b0;
          req_type_i  <= 1'($urandom_range(0, 1));
          data_bits_i <= DataBits'($urandom_range(0, 255));
          bit_count_i <= CountBits'($urandom_range(0, 15));
        end else begin
          item = pending_items.pop_front();
          in_valid_i  <= 1'b1;
          req_type_i  <= item.req;
          data_bits_i <= item.data;
          bit_count_i <= item.count;
          idle_left = draw_idle();
        end
      end
    end
  end

  // Output monitor. Each completed output transfer is checked against the oldest
  // expected character; after it, ready is held low for a drawn number of cycles.
  always @(posedge clk_i or negedge rst_ni) begin : check_output
    char_entry_t want;
    int unsigned stall_left;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h with nothing expected", out_char_o));
        end else begin
          want = expected_chars.pop_front();
          if (out_char_o !== want.ascii) begin
            report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                      out_char_o, want.ascii));
          end
          if (last_o !== want.last) begin
            report_mismatch($sformatf("last %b, expected %b for char 0x%02h",
                                      last_o, want.last, want.ascii));
          end
        end
        stall_left = draw_idle();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned counted;
    int unsigned kind;
    int unsigned len;

    // Directed part: empty flush out of reset, zero and oversized counts, every
    // count from one to eight, all-zero and all-one data, the symbols at both ends
    // of the alphabet and '+', and flushes with and without pending bits.
    add_flush();
    add_write(8'hFF, 4'd0);
    add_write(8'h00, 4'd6);
    add_write(8'h3F, 4'd6);
    add_write(8'h3E, 4'd6);
    add_write(8'hFF, 4'd8);
    add_write(8'h00, 4'd8);
    add_write(8'hFF, 4'd15);
    add_write(8'h01, 4'd1);
    add_flush();
    add_flush();
    add_write(8'hFE, 4'd2);
    add_write(8'h05, 4'd3);
    add_write(8'hFA, 4'd4);
    add_write(8'h15, 4'd5);
    add_write(8'hC0, 4'd7);
    add_write(8'hAA, 4'd9);
    add_write(8'h55, 4'd12);
    add_flush();
    add_write(8'h80, 4'd8);
    add_write(8'h7F, 4'd8);
    add_write(8'hFF, 4'd0);
    add_flush();

    // Random part. Most of it is runs of whole bytes, as real Base64 input, often
    // closed by a flush; the rest is mixed-width groups, lone flushes and writes
    // with zero or oversized counts.
    counted = 0;
    while (counted < RandomItems) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        len = $urandom_range(1, 4);
        repeat (len) add_write(DataBits'($urandom_range(0, 255)), 4'd8);
        counted += len;
        if ($urandom_range(0, 1) == 1) begin
          add_flush();
          counted++;
        end
      end else if (kind <= 7) begin
        len = $urandom_range(1, 6);
        repeat (len) add_write(DataBits'($urandom_range(0, 255)),
                               CountBits'($urandom_range(1, 8)));
        counted += len;
      end else if (kind == 8) begin
        add_flush();
        counted++;
      end else if ($urandom_range(0, 1) == 1) begin
        // A zero count leaves the block untouched, so it does not count as an item.
        add_write(DataBits'($urandom_range(0, 255)), 4'd0);
      end else begin
        add_write(DataBits'($urandom_range(0, 255)), CountBits'($urandom_range(9, 15)));
        counted++;
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Run until every item has been transferred and every character has arrived.
    while ((pending_items.size() != 0 || in_valid_i || expected_chars.size() != 0)
           && cycle_count < CycleLimit) begin
      @(posedge clk_i);
    end
    if (cycle_count >= CycleLimit) begin
      timed_out = 1'b1;
    end else begin
      // Give a stray extra character time to show up.
      repeat (DrainCycles) @(posedge clk_i);
    end
    if (expected_chars.size() != 0) begin
      report_mismatch($sformatf("%0d expected characters never arrived",
                                expected_chars.size()));
    end

    if (!timed_out && mismatch_count == 0) begin
      $display("base64_bit_packer_unit test passed");
    end else begin
      $display("base64_bit_packer_unit test failed");
    end
    $finish;
  end

endmodule

### base64_bit_packer_unit.f
+incdir+rtl
rtl/b64bp_pkg.sv
rtl/b64bp_fifo.sv
rtl/b64bp_front.sv
rtl/b64bp_back.sv
rtl/base64_bit_packer_unit.sv
rtl/b64bp_checker.sv
tb/base64_bit_packer_unit_tb.sv
